// ----- hw/rtl/accumulator_cpu_memory_ref_step_assert.svh -----
// assertion macros shared by the accumulator cpu rtl
// no dependencies; include by bare file name inside a module body
`ifndef ACCUMULATOR_CPU_MEMORY_REF_STEP_ASSERT_SVH
`define ACCUMULATOR_CPU_MEMORY_REF_STEP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ACMR_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ACMR_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/acmr_pkg.sv -----
// shared types and constants for the accumulator cpu
// no dependencies
package acmr_pkg;

  localparam int WORD_W = 12;
  localparam int MEMORY_WORDS_DEF = 4096;

  // request operation codes
  localparam logic [1:0] OP_EXEC  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // instruction opcodes, bits 11..9
  localparam logic [2:0] OPC_AND = 3'd0;
  localparam logic [2:0] OPC_TAD = 3'd1;
  localparam logic [2:0] OPC_ISZ = 3'd2;
  localparam logic [2:0] OPC_DCA = 3'd3;
  localparam logic [2:0] OPC_JMS = 3'd4;
  localparam logic [2:0] OPC_JMP = 3'd5;

  // instruction word fields
  localparam int BIT_INDIRECT = 8;
  localparam int BIT_PAGE     = 7;

  // core access request
  typedef struct packed {
    logic              en;
    logic              we;
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

endpackage

// ----- hw/rtl/acmr_core.sv -----
// single-port synchronous core memory with registered read data
// depends on acmr_pkg; folds every address modulo the core depth (depth of 256 or more)
module acmr_core #(
  parameter int MEMORY_WORDS = acmr_pkg::MEMORY_WORDS_DEF
) (
  input  logic                           clk,
  input  acmr_pkg::mem_req_t             req,
  output logic [acmr_pkg::WORD_W-1:0]    rdata
);
  import acmr_pkg::*;

  localparam int AW = $clog2(MEMORY_WORDS);
  localparam int RW = WORD_W + 4;
  localparam logic [RW-1:0] DEPTH_R = RW'(MEMORY_WORDS);

  logic [WORD_W-1:0] mem [MEMORY_WORDS];
  logic [AW-1:0]     idx;

  // address modulo depth by four conditional subtracts, exact while the quotient is below 16
  function automatic logic [AW-1:0] fold(input logic [WORD_W-1:0] a);
    logic [RW-1:0] r;
    r = {4'd0, a};
    for (int k = 3; k >= 0; k--) begin
      if (r >= (DEPTH_R << k)) begin
        r = r - (DEPTH_R << k);
      end
    end
    return r[AW-1:0];
  endfunction

  assign idx = fold(req.addr);

  // one access per cycle, read data registered
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[idx] <= req.wdata;
      end else begin
        rdata <= mem[idx];
      end
    end
  end

endmodule

// ----- hw/rtl/acmr_seq.sv -----
// instruction sequencer: registers, core access control and result register
// depends on acmr_pkg and the assertion macro header
module acmr_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    operation,
  input  logic [acmr_pkg::WORD_W-1:0]   address,
  input  logic [acmr_pkg::WORD_W-1:0]   data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [acmr_pkg::WORD_W-1:0]   program_counter,
  output logic [acmr_pkg::WORD_W-1:0]   accumulator,
  output logic                          link,
  output logic [acmr_pkg::WORD_W-1:0]   read_data,
  output logic                          not_implemented,
  output acmr_pkg::mem_req_t            mem_req,
  input  logic [acmr_pkg::WORD_W-1:0]   mem_rdata
);
  import acmr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ISSUE = 7'b0000010,
    S_INSTR = 7'b0000100,
    S_PEEK  = 7'b0001000,
    S_INDIR = 7'b0010000,
    S_OPND  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t            state;
  logic [1:0]        op_q;
  logic [WORD_W-1:0] addr_q;
  logic [WORD_W-1:0] data_q;
  logic [WORD_W-1:0] pc;
  logic [WORD_W-1:0] acc;
  logic              lnk;
  logic [2:0]        opc_q;
  logic [WORD_W-1:0] ea_q;
  logic [WORD_W-1:0] rd;
  logic              noimp;

  logic              accept;
  logic              done_fire;
  logic [2:0]        opc_w;
  logic              opc_unimp;
  logic [WORD_W-1:0] ea_dir;
  logic [WORD_W-1:0] ea_cur;
  logic [2:0]        opc_cur;
  logic [WORD_W-1:0] pc_adv;
  logic              dispatch;
  logic [WORD_W:0]   tad_sum;
  logic [WORD_W-1:0] isz_val;

  // handshake, input held off while in reset
  assign done_fire = (state == S_DONE) && (!out_valid || !out_stall);
  assign in_stall  = rst || !((state == S_IDLE) || done_fire);
  assign accept    = in_valid && !in_stall;

  // instruction decode from the fetched word or the indirect pointer
  assign opc_w     = mem_rdata[11:9];
  assign opc_unimp = (opc_w[2:1] == 2'b11);
  assign ea_dir    = {(mem_rdata[BIT_PAGE] ? pc[11:7] : 5'd0), mem_rdata[6:0]};
  assign ea_cur    = (state == S_INDIR) ? mem_rdata : ea_dir;
  assign opc_cur   = (state == S_INDIR) ? opc_q : opc_w;
  assign pc_adv    = (state == S_INSTR) ? pc + 12'd1 : pc;
  assign dispatch  = ((state == S_INSTR) && !opc_unimp && !mem_rdata[BIT_INDIRECT])
                     || (state == S_INDIR);
  assign tad_sum   = {1'b0, mem_rdata} + {1'b0, acc};
  assign isz_val   = mem_rdata + 12'd1;

  // core access for the current step
  always_comb begin
    mem_req = '0;
    case (state)
      S_ISSUE: begin
        case (op_q)
          OP_EXEC: begin
            mem_req.en   = 1'b1;
            mem_req.addr = pc;
          end
          OP_WRITE: begin
            mem_req.en    = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = addr_q;
            mem_req.wdata = data_q;
          end
          OP_READ: begin
            mem_req.en   = 1'b1;
            mem_req.addr = addr_q;
          end
          default: begin
          end
        endcase
      end
      S_INSTR: begin
        if (!opc_unimp && mem_rdata[BIT_INDIRECT]) begin
          mem_req.en   = 1'b1;
          mem_req.addr = ea_dir;
        end
      end
      S_OPND: begin
        if (opc_q == OPC_ISZ) begin
          mem_req.en    = 1'b1;
          mem_req.we    = 1'b1;
          mem_req.addr  = ea_q;
          mem_req.wdata = isz_val;
        end
      end
      default: begin
      end
    endcase
    // final effective address known: operand read or store
    if (dispatch) begin
      case (opc_cur)
        OPC_AND, OPC_TAD, OPC_ISZ: begin
          mem_req.en   = 1'b1;
          mem_req.addr = ea_cur;
        end
        OPC_DCA: begin
          mem_req.en    = 1'b1;
          mem_req.we    = 1'b1;
          mem_req.addr  = ea_cur;
          mem_req.wdata = acc;
        end
        OPC_JMS: begin
          mem_req.en    = 1'b1;
          mem_req.we    = 1'b1;
          mem_req.addr  = ea_cur;
          mem_req.wdata = pc_adv;
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer and architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pc        <= '0;
      acc       <= '0;
      lnk       <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_ISSUE: begin
          case (op_q)
            OP_EXEC: state <= S_INSTR;
            OP_READ: state <= S_PEEK;
            default: state <= S_DONE;
          endcase
        end
        S_PEEK: begin
          rd    <= mem_rdata;
          state <= S_DONE;
        end
        S_INSTR: begin
          pc    <= pc + 12'd1;
          opc_q <= opc_w;
          if (opc_unimp) begin
            noimp <= 1'b1;
            state <= S_DONE;
          end else if (mem_rdata[BIT_INDIRECT]) begin
            state <= S_INDIR;
          end
        end
        S_OPND: begin
          case (opc_q)
            OPC_AND: acc <= acc & mem_rdata;
            OPC_TAD: begin
              acc <= tad_sum[WORD_W-1:0];
              lnk <= lnk ^ tad_sum[WORD_W];
            end
            OPC_ISZ: begin
              if (isz_val == '0) begin
                pc <= pc + 12'd1;
              end
            end
            default: begin
            end
          endcase
          state <= S_DONE;
        end
        S_DONE: begin
          if (done_fire) begin
            program_counter <= pc;
            accumulator     <= acc;
            link            <= lnk;
            read_data       <= rd;
            not_implemented <= noimp;
            out_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: begin
        end
      endcase
      // execute once the effective address is final
      if (dispatch) begin
        ea_q <= ea_cur;
        case (opc_cur)
          OPC_AND, OPC_TAD, OPC_ISZ: state <= S_OPND;
          OPC_DCA: begin
            acc   <= '0;
            state <= S_DONE;
          end
          OPC_JMS: begin
            pc    <= ea_cur + 12'd1;
            state <= S_DONE;
          end
          default: begin
            pc    <= ea_cur;
            state <= S_DONE;
          end
        endcase
      end
      // new request
      if (accept) begin
        op_q   <= operation;
        addr_q <= address;
        data_q <= data;
        rd     <= '0;
        noimp  <= 1'b0;
        state  <= S_ISSUE;
      end
    end
  end

  `include "accumulator_cpu_memory_ref_step_assert.svh"

  `ACMR_ASSERT_NXT(a_accept_issue, clk, rst, accept, state == S_ISSUE,
                   "accepted request did not issue")
  `ACMR_ASSERT_IMP(a_opnd_origin, clk, rst, state == S_OPND,
                   $past(state) == S_INSTR || $past(state) == S_INDIR,
                   "operand step without address step")
  `ACMR_ASSERT_IMP(a_no_idle_write, clk, rst, state == S_IDLE || state == S_DONE,
                   !mem_req.we, "core write outside execution")
  `ACMR_ASSERT_NXT(a_done_hold, clk, rst, state == S_DONE && out_valid && out_stall,
                   state == S_DONE && out_valid, "finished result dropped while stalled")

endmodule

// ----- hw/rtl/accumulator_cpu_memory_ref_step.sv -----
// 12-bit accumulator processor, memory-reference instructions only
// Requests enter on operation/address/data with in_valid and in_stall;
// operation 0 executes the instruction at the program counter, 1 writes
// a core word, 2 reads one, 3 only reports the registers.
// Every request gives one result on the out_* ports with out_valid and
// out_stall: program counter, accumulator, link, read word, and a flag for
// opcodes six and seven, which act as no-ops.
// The fetch, indirect read, operand read and write-back share the single core
// memory port, so a request steps through issue, decode, an indirect read if
// the instruction asks for one (not for opcodes six and seven), and for AND,
// TAD and ISZ an operand step, in which ISZ writes back. The next request is
// taken in the cycle the previous result moves to the output register.
// While the receiver stalls, the result register holds; one further request
// is worked off and waits to finish until the register frees.
// Reset clears program counter, accumulator and link and holds the input
// stalled while it is high; core contents are undefined until written and
// no clearing pass runs.
module accumulator_cpu_memory_ref_step #(
  parameter int MEMORY_WORDS = acmr_pkg::MEMORY_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    operation,
  input  logic [acmr_pkg::WORD_W-1:0]   address,
  input  logic [acmr_pkg::WORD_W-1:0]   data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [acmr_pkg::WORD_W-1:0]   program_counter,
  output logic [acmr_pkg::WORD_W-1:0]   accumulator,
  output logic                          link,
  output logic [acmr_pkg::WORD_W-1:0]   read_data,
  output logic                          not_implemented
);
  import acmr_pkg::*;

  mem_req_t          mem_req;
  logic [WORD_W-1:0] mem_rdata;

  // sequencer and registers
  acmr_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .address         (address),
    .data            (data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .program_counter (program_counter),
    .accumulator     (accumulator),
    .link            (link),
    .read_data       (read_data),
    .not_implemented (not_implemented),
    .mem_req         (mem_req),
    .mem_rdata       (mem_rdata)
  );

  // core memory
  acmr_core #(
    .MEMORY_WORDS (MEMORY_WORDS)
  ) u_core (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

// ----- sim/tb.sv -----
// self-checking testbench for accumulator_cpu_memory_ref_step: directed and random requests
// with an in-line cpu predictor; depends on acmr_pkg and the rtl top level only
module tb;
  import acmr_pkg::*;

  localparam logic [2:0] OPC_NOP6 = 3'd6;
  localparam logic [2:0] OPC_NOP7 = 3'd7;
  localparam int IDLE_PCT = 13;
  localparam int HOLD_CYCLES = 150;
  localparam int RANDOM_END = 610;

  typedef struct packed {
    logic [WORD_W-1:0] pc;
    logic [WORD_W-1:0] acc;
    logic              lnk;
    logic [WORD_W-1:0] rd;
    logic              noimp;
  } cpu_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        operation = OP_NONE;
  logic [WORD_W-1:0] address = '0;
  logic [WORD_W-1:0] data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] program_counter;
  logic [WORD_W-1:0] accumulator;
  logic              link;
  logic [WORD_W-1:0] read_data;
  logic              not_implemented;

  // predictor state: core image, written marks, registers
  logic [WORD_W-1:0] core_img [0:4095];
  bit                core_set [0:4095];
  logic [WORD_W-1:0] written_addrs [$];
  logic [WORD_W-1:0] pc_q = '0;
  logic [WORD_W-1:0] acc_q = '0;
  logic              link_q = 1'b0;

  cpu_result_t predicted_results [$];
  cpu_result_t want_r;
  int          n_errors = 0;
  int          n_requests = 0;
  bit          calm = 1'b0;
  bit          hold_off_go = 1'b0;

  accumulator_cpu_memory_ref_step uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .address         (address),
    .data            (data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .program_counter (program_counter),
    .accumulator     (accumulator),
    .link            (link),
    .read_data       (read_data),
    .not_implemented (not_implemented)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // hard stop if the run hangs
  initial begin
    #200000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [11:0] encode_instr(input logic [2:0] opc, input bit ind,
                                               input bit pg, input logic [6:0] low);
    return {opc, ind, pg, low};
  endfunction

  // low seven bits, with the page of the instruction's own address when asked
  function automatic logic [11:0] direct_addr(input logic [11:0] instr, input logic [11:0] here);
    logic [11:0] a;
    a = {5'd0, instr[6:0]};
    if (instr[BIT_PAGE]) a[11:7] = here[11:7];
    return a;
  endfunction

  function automatic void store_word(input logic [11:0] a, input logic [11:0] w);
    if (!core_set[a]) written_addrs.push_back(a);
    core_set[a] = 1'b1;
    core_img[a] = w;
  endfunction

  // one request through the cpu: updates the predictor state, returns the result
  function automatic cpu_result_t step_cpu(input logic [1:0] op, input logic [11:0] adr,
                                           input logic [11:0] dat);
    cpu_result_t r;
    logic [11:0] here, instr, ea, w;
    logic [12:0] sum;
    logic [2:0]  opc;
    r = '0;
    case (op)
      OP_EXEC: begin
        here = pc_q;
        instr = core_img[here];
        opc = instr[11:9];
        pc_q = here + 12'd1;
        if (opc > OPC_JMP) begin
          r.noimp = 1'b1;
        end else begin
          ea = direct_addr(instr, here);
          if (instr[BIT_INDIRECT]) ea = core_img[ea];
          case (opc)
            OPC_AND: acc_q = acc_q & core_img[ea];
            OPC_TAD: begin
              sum = {1'b0, acc_q} + {1'b0, core_img[ea]};
              acc_q = sum[11:0];
              if (sum[12]) link_q = ~link_q;
            end
            OPC_ISZ: begin
              w = core_img[ea] + 12'd1;
              store_word(ea, w);
              if (w == 12'd0) pc_q = pc_q + 12'd1;
            end
            OPC_DCA: begin
              store_word(ea, acc_q);
              acc_q = '0;
            end
            OPC_JMS: begin
              store_word(ea, pc_q);
              pc_q = ea + 12'd1;
            end
            default: pc_q = ea;
          endcase
        end
      end
      OP_WRITE: store_word(adr, dat);
      OP_READ:  r.rd = core_img[adr];
      default: ;
    endcase
    r.pc = pc_q;
    r.acc = acc_q;
    r.lnk = link_q;
    return r;
  endfunction

  // data words lean toward all ones, zero and low addresses
  function automatic logic [11:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 12'o7777;
      1:       return 12'o0000;
      2, 3:    return 12'($urandom_range(0, 'o377));
      default: return 12'($urandom_range(0, 'o7777));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [11:0] got,
                                 input logic [11:0] want);
    if (n_errors < 50) $display("mismatch %s: got %o want %o at %0t", what, got, want, $time);
    n_errors++;
  endtask

  // one request: optional idle gap, then hold until accepted
  task automatic send_req(input logic [1:0] op, input logic [11:0] adr, input logic [11:0] dat);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(0, 99) < IDLE_PCT);
    end
    in_valid <= 1'b1;
    operation <= op;
    address <= adr;
    data <= dat;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    predicted_results.push_back(step_cpu(op, adr, dat));
    n_requests++;
  endtask

  // load whatever the next instruction will read, then execute it
  task automatic run_instruction(input bit reuse);
    logic [11:0] instr, ea;
    if (!reuse || !core_set[pc_q]) send_req(OP_WRITE, pc_q, 12'($urandom_range(0, 'o7777)));
    instr = core_img[pc_q];
    if (instr[11:9] <= OPC_JMP) begin
      ea = direct_addr(instr, pc_q);
      if (instr[BIT_INDIRECT]) begin
        if (!core_set[ea]) send_req(OP_WRITE, ea, rand_word());
        ea = core_img[ea];
      end
      // and, tad and isz read their operand
      if (instr[11:9] < OPC_DCA && !core_set[ea]) send_req(OP_WRITE, ea, rand_word());
    end
    send_req(OP_EXEC, 12'($urandom_range(0, 'o7777)), 12'($urandom_range(0, 'o7777)));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // write zero to octal 4000 and read it back, plus the unused operation
  task automatic test_load_peek();
    send_req(OP_WRITE, 12'o4000, 12'o0000);
    send_req(OP_READ, 12'o4000, 12'o7777);
    send_req(OP_NONE, 12'o7777, 12'o7777);
  endtask

  // short program: every opcode, carry into link, isz skip, page prefix,
  // indirection, jms return address at the top word and pc wrap to zero
  task automatic test_instruction_set();
    send_req(OP_WRITE, 12'o0100, 12'o7777);
    send_req(OP_WRITE, 12'o0101, 12'o5252);
    send_req(OP_WRITE, 12'o0102, 12'o2530);
    send_req(OP_WRITE, 12'o0103, 12'o7776);
    send_req(OP_WRITE, 12'o0000, encode_instr(OPC_TAD, 0, 0, 7'o100));
    send_req(OP_WRITE, 12'o0001, encode_instr(OPC_AND, 0, 0, 7'o101));
    send_req(OP_WRITE, 12'o0002, encode_instr(OPC_TAD, 0, 0, 7'o102));
    send_req(OP_WRITE, 12'o0003, encode_instr(OPC_ISZ, 0, 0, 7'o100));
    send_req(OP_WRITE, 12'o0005, encode_instr(OPC_DCA, 0, 0, 7'o100));
    send_req(OP_WRITE, 12'o0006, encode_instr(OPC_NOP6, 0, 0, 7'o000));
    send_req(OP_WRITE, 12'o0007, encode_instr(OPC_NOP7, 1, 1, 7'o177));
    send_req(OP_WRITE, 12'o0010, encode_instr(OPC_JMP, 1, 0, 7'o103));
    send_req(OP_WRITE, 12'o7776, encode_instr(OPC_JMS, 0, 1, 7'o177));
    repeat (9) send_req(OP_EXEC, 12'($urandom_range(0, 'o7777)),
                        12'($urandom_range(0, 'o7777)));
    send_req(OP_READ, 12'o7777, 12'o0000);
    send_req(OP_READ, 12'o0100, 12'o7777);
    send_req(OP_READ, 12'o0000, 12'o0000);
  endtask

  // mostly running programs with random content, some stray loads and peeks
  task automatic test_random_programs();
    int pick;
    while (n_requests < RANDOM_END) begin
      calm = (n_requests > 250 && n_requests < 350);
      pick = $urandom_range(0, 99);
      if (pick < 65)
        run_instruction($urandom_range(0, 99) < 40);
      else if (pick < 80)
        send_req(OP_WRITE, 12'($urandom_range(0, 'o7777)), rand_word());
      else if (pick < 95)
        send_req(OP_READ, written_addrs[$urandom_range(0, written_addrs.size() - 1)],
                 12'($urandom_range(0, 'o7777)));
      else
        send_req(OP_NONE, 12'($urandom_range(0, 'o7777)), 12'($urandom_range(0, 'o7777)));
    end
    calm = 1'b0;
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    hold_off_go = 1'b1;
    repeat (30) run_instruction(1'b1);
  endtask

  // receiver pacing, with a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // compare each accepted result with the oldest prediction
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (predicted_results.size() == 0) begin
        report_mismatch("result with no request pending", program_counter, 12'd0);
      end else begin
        want_r = predicted_results.pop_front();
        if (program_counter !== want_r.pc)
          report_mismatch("program_counter", program_counter, want_r.pc);
        if (accumulator !== want_r.acc)
          report_mismatch("accumulator", accumulator, want_r.acc);
        if (link !== want_r.lnk)
          report_mismatch("link", {11'd0, link}, {11'd0, want_r.lnk});
        if (read_data !== want_r.rd)
          report_mismatch("read_data", read_data, want_r.rd);
        if (not_implemented !== want_r.noimp)
          report_mismatch("not_implemented", {11'd0, not_implemented}, {11'd0, want_r.noimp});
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_load_peek();
    test_instruction_set();
    test_random_programs();
    wait_drain();
    test_backpressure();
    wait_drain();
    if (n_errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/acmr_pkg.sv
hw/rtl/acmr_core.sv
hw/rtl/acmr_seq.sv
hw/rtl/accumulator_cpu_memory_ref_step.sv
sim/tb.sv
